FILE: hw/rtl/stbck_pkg.sv
// Shared widths, codes and word types of the scaled texture blitter.
package stbck_pkg;

    localparam int TEX_TEXELS_DFLT = 4096;
    localparam int FRAME_MAX       = 2048;

    localparam int TSZ_W   = 7;                // texture size and texel coordinate
    localparam int CRD_W   = 12;               // box, frame and origin registers
    localparam int POS_W   = 11;               // box position and frame coordinate
    localparam int IDX_W   = 12;               // texel index of a load word
    localparam int PIX_W   = 32;               // texel word
    localparam int PROD_W  = POS_W + TSZ_W;    // position times texture size
    localparam int TADDR_W = 2 * TSZ_W;        // fx + fy * tex_width
    localparam int CFG_A_W = 3;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_TEX_W,
        CFG_TEX_H,
        CFG_BOX_W,
        CFG_BOX_H,
        CFG_ORG_X,
        CFG_ORG_Y,
        CFG_FRM_W,
        CFG_FRM_H
    } t_cfg_idx;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_DRAW = 1'b1;

    // Item data that rides alongside the scaling divider
    typedef struct packed {
        logic             kind;
        logic             ok;      // draw pixel inside box and frame
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] val;
        logic [POS_W-1:0] dx;
        logic [POS_W-1:0] dy;
    } t_side;

    // Result word, dest_x in the lowest bits
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [POS_W-1:0] dy;
        logic [POS_W-1:0] dx;
    } t_result;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

FILE: hw/rtl/stbck_scale_div.sv
// Pipelined restoring divider that scales both box coordinates to texel coordinates.
module stbck_scale_div import stbck_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  t_side             i_side,
    input  logic [PROD_W-1:0] i_px,
    input  logic [PROD_W-1:0] i_py,
    input  logic [CRD_W-1:0]  i_box_w,
    input  logic [CRD_W-1:0]  i_box_h,
    output logic              o_vld,
    output t_side             o_side,
    output logic [TSZ_W-1:0]  o_fx,
    output logic [TSZ_W-1:0]  o_fy
);

    localparam int QW = TSZ_W;

    logic              r_vld  [0:QW];
    t_side             r_side [0:QW];
    logic [PROD_W-1:0] r_rx   [0:QW];
    logic [PROD_W-1:0] r_ry   [0:QW];
    logic [QW-1:0]     r_qx   [0:QW];
    logic [QW-1:0]     r_qy   [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= i_side;
            r_rx[0]   <= i_px;
            r_ry[0]   <= i_py;
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int SH = QW - 1 - k;
        logic [PROD_W:0] w_dvx;
        logic [PROD_W:0] w_dvy;
        logic            w_bx;
        logic            w_by;

        assign w_dvx = (PROD_W+1)'(i_box_w) << SH;
        assign w_dvy = (PROD_W+1)'(i_box_h) << SH;
        assign w_bx  = {1'b0, r_rx[k]} >= w_dvx;
        assign w_by  = {1'b0, r_ry[k]} >= w_dvy;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k+1] <= r_side[k];
                r_rx[k+1]   <= w_bx ? PROD_W'({1'b0, r_rx[k]} - w_dvx) : r_rx[k];
                r_ry[k+1]   <= w_by ? PROD_W'({1'b0, r_ry[k]} - w_dvy) : r_ry[k];
                r_qx[k+1]   <= {r_qx[k][QW-2:0], w_bx};
                r_qy[k+1]   <= {r_qy[k][QW-2:0], w_by};
            end
        end
    end

    assign o_vld  = r_vld[QW];
    assign o_side = r_side[QW];
    assign o_fx   = r_qx[QW];
    assign o_fy   = r_qy[QW];

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(o_vld) && $stable(o_fx) && $stable(o_fy))
        else $error("divider output moved while stalled");

endmodule

FILE: hw/rtl/stbck_tex_mem.sv
// Texture store: single-port synchronous memory with registered read data.
module stbck_tex_mem import stbck_pkg::*; #(
    parameter int TEX_TEXELS = TEX_TEXELS_DFLT
) (
    input  logic                          i_clk,
    input  t_mem_ctl                      i_ctl,
    input  logic [$clog2(TEX_TEXELS)-1:0] i_addr,
    input  logic [PIX_W-1:0]              i_wdata,
    output logic [PIX_W-1:0]              o_rdata
);

    logic [PIX_W-1:0] r_mem [TEX_TEXELS];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/stbck_out_skid.sv
// Output register with a skid stage between the pipeline and the result stream.
module stbck_out_skid import stbck_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_vld,
    output t_result o_data,
    input  logic    i_out_ready
);

    logic    r_out_vld;
    logic    r_skd_vld;
    t_result r_out;
    t_result r_skd;
    logic    w_load_out;

    assign o_ready    = !r_skd_vld;
    assign w_load_out = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (w_load_out) begin
            // drain the skid first, else take the incoming word
            if (r_skd_vld) begin
                r_out_vld <= 1'b1;
                r_skd_vld <= 1'b0;
            end else begin
                r_out_vld <= i_vld;
            end
        end else if (i_vld && !r_skd_vld) begin
            r_skd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= r_skd_vld ? r_skd : i_data;
        end else if (i_vld && !r_skd_vld) begin
            r_skd <= i_data;
        end
    end

    assign o_vld  = r_out_vld;
    assign o_data = r_out;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid holds a word while output register is empty");

    a_skid_catches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !i_out_ready && i_vld && o_ready |=> r_skd_vld && r_out_vld)
        else $error("word lost while output stalled");

endmodule

FILE: hw/rtl/scaled_texture_blit_color_key.sv
// Throughput: one word per cycle, loads and draws alike, unless the output stalls; the 7-stage
// scaling divider, the texel-address multiply and the registered texture store read form the pipe.
// A full output plus skid stage stalls the whole pipe; results wait without loss.
// Reset (synchronous): clears all valid bits and loads the register defaults.
// The texture store is not cleared; a texel reads as undefined until loaded.
module scaled_texture_blit_color_key import stbck_pkg::*; #(
    parameter int TEX_TEXELS = TEX_TEXELS_DFLT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input stream
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [71:0]        i_s_tdata,   // texel_index, texel_value, box_col, box_row, zero pad
    input  logic [0:0]         i_s_tuser,   // kind
    // result stream
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [55:0]        o_m_tdata,   // dest_x, dest_y, pixel_value, zero pad
    // register writes
    input  logic               i_cfg_we,
    input  logic [CFG_A_W-1:0] i_cfg_addr,
    input  logic [CRD_W-1:0]   i_cfg_wdata
);

    localparam int              AW      = $clog2(TEX_TEXELS);
    localparam logic [CRD_W+1:0] FRM_LIM = (CRD_W+2)'(FRAME_MAX);

    // configuration registers
    logic [TSZ_W-1:0] r_tex_w;
    logic [TSZ_W-1:0] r_tex_h;
    logic [CRD_W-1:0] r_box_w;
    logic [CRD_W-1:0] r_box_h;
    logic [CRD_W-1:0] r_org_x;
    logic [CRD_W-1:0] r_org_y;
    logic [CRD_W-1:0] r_frm_w;
    logic [CRD_W-1:0] r_frm_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_w <= TSZ_W'(64);
            r_tex_h <= TSZ_W'(64);
            r_box_w <= CRD_W'(64);
            r_box_h <= CRD_W'(64);
            r_org_x <= '0;
            r_org_y <= '0;
            r_frm_w <= CRD_W'(640);
            r_frm_h <= CRD_W'(480);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_TEX_W: r_tex_w <= i_cfg_wdata[TSZ_W-1:0];
                CFG_TEX_H: r_tex_h <= i_cfg_wdata[TSZ_W-1:0];
                CFG_BOX_W: r_box_w <= i_cfg_wdata;
                CFG_BOX_H: r_box_h <= i_cfg_wdata;
                CFG_ORG_X: r_org_x <= i_cfg_wdata;
                CFG_ORG_Y: r_org_y <= i_cfg_wdata;
                CFG_FRM_W: r_frm_w <= i_cfg_wdata;
                CFG_FRM_H: r_frm_h <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // whole pipe advances unless the skid stage is full
    logic w_adv;

    // input stage
    logic             r_s1_vld;
    logic             r_s1_kind;
    logic [IDX_W-1:0] r_s1_idx;
    logic [PIX_W-1:0] r_s1_val;
    logic [POS_W-1:0] r_s1_col;
    logic [POS_W-1:0] r_s1_row;

    assign o_s_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_kind <= i_s_tuser[0];
            r_s1_idx  <= i_s_tdata[11:0];
            r_s1_val  <= i_s_tdata[43:12];
            r_s1_col  <= i_s_tdata[54:44];
            r_s1_row  <= i_s_tdata[65:55];
        end
    end

    // box test, frame placement, clipping and scaling products
    logic [CRD_W:0]    w_dx;
    logic [CRD_W:0]    w_dy;
    logic              w_in_box;
    logic              w_in_frm;
    logic [PROD_W-1:0] w_px;
    logic [PROD_W-1:0] w_py;
    t_side             w_side;

    assign w_dx = {r_org_x[CRD_W-1], r_org_x} + (CRD_W+1)'(r_s1_col);
    assign w_dy = {r_org_y[CRD_W-1], r_org_y} + (CRD_W+1)'(r_s1_row);

    assign w_in_box = (CRD_W'(r_s1_col) < r_box_w) && (CRD_W'(r_s1_row) < r_box_h);
    assign w_in_frm = !w_dx[CRD_W] && (w_dx[CRD_W-1:0] < r_frm_w)
                   && ((CRD_W+2)'(w_dx[CRD_W-1:0]) < FRM_LIM)
                   && !w_dy[CRD_W] && (w_dy[CRD_W-1:0] < r_frm_h)
                   && ((CRD_W+2)'(w_dy[CRD_W-1:0]) < FRM_LIM);

    assign w_px = PROD_W'(r_s1_col) * PROD_W'(r_tex_w);
    assign w_py = PROD_W'(r_s1_row) * PROD_W'(r_tex_h);

    always_comb begin
        w_side      = '0;
        w_side.kind = r_s1_kind;
        w_side.ok   = w_in_box && w_in_frm;
        w_side.idx  = r_s1_idx;
        w_side.val  = r_s1_val;
        w_side.dx   = w_dx[POS_W-1:0];
        w_side.dy   = w_dy[POS_W-1:0];
    end

    logic             w_div_vld;
    t_side            w_div_side;
    logic [TSZ_W-1:0] w_div_fx;
    logic [TSZ_W-1:0] w_div_fy;

    stbck_scale_div u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_vld   (r_s1_vld),
        .i_side  (w_side),
        .i_px    (w_px),
        .i_py    (w_py),
        .i_box_w (r_box_w),
        .i_box_h (r_box_h),
        .o_vld   (w_div_vld),
        .o_side  (w_div_side),
        .o_fx    (w_div_fx),
        .o_fy    (w_div_fy)
    );

    // row offset multiply
    logic               r_m_vld;
    t_side              r_m_side;
    logic [TSZ_W-1:0]   r_m_fx;
    logic [TADDR_W-1:0] r_m_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_adv) begin
            r_m_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m_side <= w_div_side;
            r_m_fx   <= w_div_fx;
            r_m_prod <= TADDR_W'(w_div_fy) * TADDR_W'(r_tex_w);
        end
    end

    // store access: loads write, draws read; one item per cycle, held while stalled, keeps program order
    logic [TADDR_W-1:0] w_taddr;
    logic               w_rd_ok;
    logic               w_wr_ok;
    logic               w_is_draw;
    t_mem_ctl           w_mem_ctl;
    logic [AW-1:0]      w_mem_addr;
    logic [PIX_W-1:0]   w_mem_rdata;

    assign w_taddr   = TADDR_W'(r_m_fx) + r_m_prod;
    assign w_rd_ok   = int'(w_taddr) < TEX_TEXELS;
    assign w_wr_ok   = int'(r_m_side.idx) < TEX_TEXELS;
    assign w_is_draw = r_m_side.kind == KIND_DRAW;

    assign w_mem_ctl.we = w_adv && r_m_vld && !w_is_draw && w_wr_ok;
    assign w_mem_ctl.re = w_adv && r_m_vld && w_is_draw && r_m_side.ok && w_rd_ok;
    assign w_mem_addr   = w_is_draw ? AW'(w_taddr) : AW'(r_m_side.idx);

    stbck_tex_mem #(
        .TEX_TEXELS (TEX_TEXELS)
    ) u_tex_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_addr  (w_mem_addr),
        .i_wdata (r_m_side.val),
        .o_rdata (w_mem_rdata)
    );

    // read data stage: only draws that passed every test reach it
    logic             r_q_vld;
    logic [POS_W-1:0] r_q_dx;
    logic [POS_W-1:0] r_q_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else if (w_adv) begin
            r_q_vld <= r_m_vld && w_is_draw && r_m_side.ok && w_rd_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_q_dx <= r_m_side.dx;
            r_q_dy <= r_m_side.dy;
        end
    end

    // color key: drop black texels
    logic    w_res_vld;
    t_result w_res;
    t_result w_out;

    assign w_res_vld   = r_q_vld && (w_mem_rdata[23:0] != 24'd0);
    assign w_res.pixel = w_mem_rdata;
    assign w_res.dy    = r_q_dy;
    assign w_res.dx    = r_q_dx;

    stbck_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (w_res_vld),
        .i_data      (w_res),
        .o_ready     (w_adv),
        .o_vld       (o_m_tvalid),
        .o_data      (w_out),
        .i_out_ready (i_m_tready)
    );

    assign o_m_tdata = {2'b00, w_out};

    a_key_drops_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[45:22] != 24'd0))
        else $error("black texel reached the output");

    a_read_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_mem_rdata))
        else $error("texel read data changed while stalled");

    a_stage_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv && r_q_vld |=> r_q_vld && $stable(r_q_dx) && $stable(r_q_dy))
        else $error("read stage moved while stalled");

endmodule

FILE: dv/tb_scaled_texture_blit_color_key.sv
// Self-checking stream testbench for the scaled texture blitter with black color key.
module tb_scaled_texture_blit_color_key;
    import stbck_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int PIPE_LAT       = 11;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] val;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
    } t_blit_word;

    typedef struct {
        logic [TSZ_W-1:0]        tw;
        logic [TSZ_W-1:0]        th;
        logic [CRD_W-1:0]        bw;
        logic [CRD_W-1:0]        bh;
        logic signed [CRD_W-1:0] ox;
        logic signed [CRD_W-1:0] oy;
        logic [CRD_W-1:0]        fw;
        logic [CRD_W-1:0]        fh;
    } t_blit_cfg;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [71:0]        i_s_tdata;   // texel_index, texel_value, box_col, box_row, zero pad
    logic [0:0]         i_s_tuser;   // kind
    logic               o_m_tvalid;
    logic               i_m_tready = 1'b0;
    logic [55:0]        o_m_tdata;   // dest_x, dest_y, pixel_value, zero pad
    logic               i_cfg_we;
    logic [CFG_A_W-1:0] i_cfg_addr;
    logic [CRD_W-1:0]   i_cfg_wdata;

    // Shadow copy of the block: registers and texture store
    t_blit_cfg   cfg = '{7'd64, 7'd64, 12'd64, 12'd64, 12'sd0, 12'sd0, 12'd640, 12'd480};
    logic [31:0] texels [TEX_TEXELS_DFLT];
    bit          loaded [TEX_TEXELS_DFLT];
    t_result     expected_px [$];

    int unsigned errors;
    int unsigned idle_cycles;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    t_result     got_px;
    t_result     want_px;

    scaled_texture_blit_color_key DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_wdata(i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Texel address of a box pixel; false when outside the box or past the store
    function automatic bit store_read(input logic [POS_W-1:0] col, row,
                                      output int unsigned addr);
        int unsigned cu, ru, fx, fy;
        addr = 0;
        if (col >= cfg.bw || row >= cfg.bh) return 1'b0;
        cu   = col;
        ru   = row;
        fx   = (cu * cfg.tw) / cfg.bw;
        fy   = (ru * cfg.th) / cfg.bh;
        addr = fx + fy * cfg.tw;
        return addr < TEX_TEXELS_DFLT;
    endfunction

    function automatic bit on_frame(input int v, input logic [CRD_W-1:0] lim);
        return v >= 0 && v < int'(lim) && v < FRAME_MAX;
    endfunction

    function automatic bit blit_pixel(input logic [POS_W-1:0] col, row, output t_result px);
        int unsigned addr;
        int          dx;
        int          dy;
        logic [31:0] texel;
        px = '0;
        if (!store_read(col, row, addr)) return 1'b0;
        texel = texels[addr];
        dx    = int'(cfg.ox) + int'(col);
        dy    = int'(cfg.oy) + int'(row);
        if (!on_frame(dx, cfg.fw) || !on_frame(dy, cfg.fh)) return 1'b0;
        // black key: red, green and blue all zero
        if (texel[23:0] == 24'd0) return 1'b0;
        px.dx    = dx[POS_W-1:0];
        px.dy    = dy[POS_W-1:0];
        px.pixel = texel;
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_texel();
        logic [31:0] v;
        v = $urandom;
        if ($urandom_range(99) < 15) v &= 32'hFF00_0000;
        return v;
    endfunction

    function automatic logic [POS_W-1:0] pick_coord(input logic [CRD_W-1:0] size);
        int unsigned r;
        int unsigned hi;
        r = $urandom_range(99);
        if (size == 0 || r >= 90) return POS_W'($urandom);
        if (r >= 80 && size <= 2047) return POS_W'($urandom_range(2047, size));
        hi = (size > 2048) ? 2047 : size - 1;
        return POS_W'($urandom_range(hi, 0));
    endfunction

    task automatic send_word(input t_blit_word w);
        t_result px;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'd0, w.row, w.col, w.val, w.idx};
        i_s_tuser  <= w.kind;
        do @(posedge i_clk); while (!o_s_tready);
        if (w.kind == KIND_LOAD) begin
            texels[w.idx] = w.val;
            loaded[w.idx] = 1'b1;
        end else if (blit_pixel(w.col, w.row, px)) begin
            expected_px.push_back(px);
        end
    endtask

    task automatic load_texel(input logic [IDX_W-1:0] idx, input logic [31:0] val);
        send_word('{KIND_LOAD, idx, val, POS_W'($urandom), POS_W'($urandom)});
    endtask

    // Load the source texel first if it was never written
    task automatic draw_at(input logic [POS_W-1:0] col, row);
        int unsigned addr;
        if (store_read(col, row, addr) && !loaded[addr])
            load_texel(IDX_W'(addr), rand_texel());
        send_word('{KIND_DRAW, IDX_W'($urandom), PIX_W'($urandom), col, row});
    endtask

    // Hold off the sender until every result is out and the pipe is empty
    task automatic drain_pipe();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_px.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx a, input logic [CRD_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= a;
        i_cfg_wdata <= v;
    endtask

    task automatic apply_cfg(input t_blit_cfg c);
        drain_pipe();
        write_reg(CFG_TEX_W, CRD_W'(c.tw));
        write_reg(CFG_TEX_H, CRD_W'(c.th));
        write_reg(CFG_BOX_W, c.bw);
        write_reg(CFG_BOX_H, c.bh);
        write_reg(CFG_ORG_X, c.ox);
        write_reg(CFG_ORG_Y, c.oy);
        write_reg(CFG_FRM_W, c.fw);
        write_reg(CFG_FRM_H, c.fh);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        cfg = c;
    endtask

    task automatic run_random(input t_blit_cfg c, input int items, input bit hold_mid);
        apply_cfg(c);
        for (int n = 0; n < items; n++) begin
            if (hold_mid && n == items / 2) drain_pipe();
            if ($urandom_range(99) < 15) load_texel(IDX_W'($urandom), rand_texel());
            else draw_at(pick_coord(c.bw), pick_coord(c.bh));
        end
    endtask

    // Reset register values: plain copies, upper-byte-only texel, black texel, box edges
    task automatic test_load_and_key();
        load_texel(12'd0, 32'hFFFF_FFFF);
        load_texel(12'd4095, 32'h0000_0001);
        load_texel(12'd1, 32'hFF00_0000);
        load_texel(12'd2, 32'h0000_0000);
        load_texel(12'd65, 32'h00FF_FFFF);
        draw_at(11'd0, 11'd0);
        draw_at(11'd63, 11'd63);
        draw_at(11'd1, 11'd0);
        draw_at(11'd2, 11'd0);
        draw_at(11'd1, 11'd1);
        draw_at(11'd64, 11'd0);
        draw_at(11'd0, 11'd2047);
    endtask

    task automatic test_box_extremes();
        apply_cfg('{7'd64, 7'd64, 12'd0, 12'd0, 12'sd0, 12'sd0, 12'd640, 12'd480});
        draw_at(11'd0, 11'd0);
        apply_cfg('{7'd64, 7'd64, 12'd4095, 12'd4095, 12'sd0, 12'sd0, 12'd2048, 12'd2048});
        draw_at(11'd2047, 11'd2047);
    endtask

    task automatic test_zero_texture();
        apply_cfg('{7'd0, 7'd0, 12'd64, 12'd64, 12'sd0, 12'sd0, 12'd640, 12'd480});
        draw_at(11'd5, 11'd7);
        apply_cfg('{7'd0, 7'd64, 12'd64, 12'd64, 12'sd0, 12'sd0, 12'd640, 12'd480});
        draw_at(11'd3, 11'd10);
    endtask

    task automatic test_clipping();
        apply_cfg('{7'd64, 7'd64, 12'd64, 12'd64, 12'sd2047, 12'sd2047, 12'd2048, 12'd2048});
        draw_at(11'd0, 11'd0);
        draw_at(11'd1, 11'd1);
        apply_cfg('{7'd64, 7'd64, 12'd64, 12'd64, -12'sd2048, -12'sd2048, 12'd640, 12'd480});
        draw_at(11'd63, 11'd63);
        apply_cfg('{7'd64, 7'd64, 12'd64, 12'd64, 12'sd0, 12'sd0, 12'd1, 12'd1});
        draw_at(11'd0, 11'd0);
        draw_at(11'd0, 11'd1);
    endtask

    // Oversized texture: far texels land past the store and give no result
    task automatic test_store_overrun();
        apply_cfg('{7'd127, 7'd127, 12'd127, 12'd127, 12'sd0, 12'sd0, 12'd640, 12'd480});
        draw_at(11'd126, 11'd126);
        draw_at(11'd0, 11'd0);
    endtask

    task automatic test_random_scaling();
        run_random('{7'd8, 7'd8, 12'd16, 12'd16, 12'sd100, 12'sd50, 12'd640, 12'd480}, 60, 1'b1);
        run_random('{7'd64, 7'd64, 12'd2048, 12'd2048, 12'sd0, 12'sd0, 12'd2048, 12'd2048},
                   60, 1'b0);
    endtask

    task automatic test_random_clipping();
        run_random('{7'd64, 7'd40, 12'd10, 12'd6, 12'sd2043, 12'sd2045, 12'd2048, 12'd2048},
                   60, 1'b0);
        run_random('{7'd20, 7'd30, 12'd50, 12'd40, -12'sd10, -12'sd5, 12'd30, 12'd20}, 60, 1'b0);
    endtask

    task automatic test_random_odd_sizes();
        run_random('{7'd127, 7'd127, 12'd200, 12'd200, 12'sd7, 12'sd9, 12'd1000, 12'd1000},
                   60, 1'b0);
        run_random('{7'd0, 7'd5, 12'd33, 12'd17, 12'sd300, 12'sd200, 12'd640, 12'd480}, 60, 1'b0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_px = t_result'(o_m_tdata[53:0]);
            if (expected_px.size() == 0) begin
                report_mismatch($sformatf("unexpected word %h", o_m_tdata));
            end else begin
                want_px = expected_px.pop_front();
                if (got_px.dx !== want_px.dx)
                    report_mismatch($sformatf("dest_x %0d, want %0d", got_px.dx, want_px.dx));
                if (got_px.dy !== want_px.dy)
                    report_mismatch($sformatf("dest_y %0d, want %0d", got_px.dy, want_px.dy));
                if (got_px.pixel !== want_px.pixel)
                    report_mismatch($sformatf("pixel_value %h, want %h",
                                              got_px.pixel, want_px.pixel));
                if (o_m_tdata[55:54] !== 2'b00)
                    report_mismatch($sformatf("pad bits %b", o_m_tdata[55:54]));
            end
        end
    end

    // Count cycles in which neither stream moves a word
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        errors         = 0;
        idle_cycles    = 0;
        send_idle_pct  = 21;
        recv_stall_pct = 56;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = KIND_LOAD;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = CFG_TEX_W;
        i_cfg_wdata    = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_load_and_key();
        test_box_extremes();
        test_zero_texture();
        test_clipping();
        test_store_overrun();
        test_random_scaling();

        send_idle_pct  = 56;
        recv_stall_pct = 21;
        test_random_clipping();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random_odd_sizes();

        drain_pipe();
        if (expected_px.size() != 0)
            report_mismatch($sformatf("%0d results never came", expected_px.size()));
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
